[hw/rtl/mf3_pkg.sv]
// Shared types and constants of the 3x3 median filter.
package mf3_pkg;

  typedef logic [7:0] pixel_t;

  typedef struct packed {
    logic advance;
    logic shift;
  } mf3_ctl_t;

  localparam int CFG_DATA_W = 12;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W = 12;
  localparam int COL_W = 10;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd768;

endpackage

[hw/rtl/mf3_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/mf3_median.sv]
// Sorted-column 3x3 window and two-stage median reduction.
module mf3_median
  import mf3_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mf3_ctl_t ctl,
  input  pixel_t   top_px,
  input  pixel_t   mid_px,
  input  pixel_t   new_px,
  output pixel_t   med_out
);

  typedef struct packed {
    pixel_t lo;
    pixel_t md;
    pixel_t hi;
  } col_t;

  function automatic pixel_t min2(pixel_t a, pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(pixel_t a, pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pixel_t med3(pixel_t a, pixel_t b, pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  col_t   new_col;
  col_t   win [3];
  pixel_t red_lo;
  pixel_t red_md;
  pixel_t red_hi;

  always_comb begin
    new_col.lo = min2(min2(top_px, mid_px), new_px);
    new_col.md = med3(top_px, mid_px, new_px);
    new_col.hi = max2(max2(top_px, mid_px), new_px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= '0;
      win[1] <= '0;
      win[2] <= '0;
    end else if (ctl.shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= new_col;
    end
  end

  // The median of nine is the median of the largest low, middle mid and smallest high.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      red_lo <= max2(max2(win[0].lo, win[1].lo), win[2].lo);
      red_md <= med3(win[0].md, win[1].md, win[2].md);
      red_hi <= min2(min2(win[0].hi, win[1].hi), win[2].hi);
    end
  end

  assign med_out = med3(red_lo, red_md, red_hi);

endmodule

[hw/rtl/median_filter_3x3_top.sv]
// Top level of the streaming 3x3 median filter.
//
// Pixels enter in raster order, one per clock when the output is taken, and each
// interior pixel yields its median with the center coordinates, registered, after
// the pixel that completes its window. The two previous rows live in one memory of
// MAX_WIDTH words of two pixels: a word is read when its column's pixel is accepted
// and written back from stage 1, so that memory port pair sets the rate of one
// pixel per cycle. A configuration write restarts the frame at row 0, column 0.
module median_filter_3x3_top
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_t                pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pixel_t                median,
  output logic [COL_W-1:0]      col,
  output logic [HEIGHT_W-1:0]   row,
  output logic                  last
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (XW + 1 > WIDTH_REG_W) ? XW + 1 : WIDTH_REG_W;

  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [HEIGHT_W-1:0] row;
    logic                last;
  } tag_t;

  logic [WIDTH_REG_W-1:0] width_reg;
  logic [HEIGHT_W-1:0]    height_reg;
  logic [XW-1:0]          col_count;
  logic [HEIGHT_W-1:0]    row_count;

  logic [WW-1:0]          width_ext;
  logic [WW-1:0]          width_use;
  logic [HEIGHT_W-1:0]    height_use;
  logic [WW-1:0]          x_inc;
  logic [HEIGHT_W:0]      y_inc;
  logic                   x_wrap;
  logic                   y_wrap;
  logic                   emit;
  logic [XW-1:0]          col_m1;
  tag_t                   tag_in;

  logic                   advance;
  logic                   in_accept;
  mf3_ctl_t               ctl;

  logic                   s1_present;
  logic                   s1_emit;
  logic                   s2_emit;
  logic                   s3_emit;
  logic [XW-1:0]          s1_x;
  pixel_t                 s1_px;
  tag_t                   s1_tag;
  tag_t                   s2_tag;
  tag_t                   s3_tag;

  logic [2*$bits(pixel_t)-1:0] line_rd;
  pixel_t                 line_top;
  pixel_t                 line_mid;
  pixel_t                 med_w;

  always_comb begin
    width_ext = WW'(width_reg);
    if (width_ext < WW'(3)) begin
      width_use = WW'(3);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_use = WW'(MAX_WIDTH);
    end else begin
      width_use = width_ext;
    end
    height_use = (height_reg < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_reg;
  end

  assign x_inc  = WW'(col_count) + WW'(1);
  assign y_inc  = {1'b0, row_count} + (HEIGHT_W + 1)'(1);
  assign x_wrap = (x_inc >= width_use);
  assign y_wrap = (y_inc >= {1'b0, height_use});
  assign emit   = (col_count >= XW'(2)) && (row_count >= HEIGHT_W'(2));
  assign col_m1 = col_count - XW'(1);

  always_comb begin
    tag_in.col  = COL_W'(col_m1);
    tag_in.row  = row_count - HEIGHT_W'(1);
    tag_in.last = x_wrap && y_wrap;
  end

  assign advance     = !(s3_emit && out_valid && !out_ready);
  assign in_ready    = advance;
  assign in_accept   = in_valid && advance;
  assign ctl.advance = advance;
  assign ctl.shift   = advance && s1_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      col_count  <= '0;
      row_count  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_reg <= cfg_data[WIDTH_REG_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          height_reg <= cfg_data[HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (x_wrap) begin
        col_count <= '0;
        row_count <= y_wrap ? '0 : y_inc[HEIGHT_W-1:0];
      end else begin
        col_count <= x_inc[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_present <= 1'b0;
      s1_emit    <= 1'b0;
      s2_emit    <= 1'b0;
      s3_emit    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        s1_present <= in_accept;
        s1_emit    <= in_accept && emit;
        s2_emit    <= s1_emit;
        s3_emit    <= s2_emit;
      end
      if (advance && s3_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x   <= col_count;
      s1_px  <= pixel;
      s1_tag <= tag_in;
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
    end
    if (advance && s3_emit) begin
      median <= med_w;
      col    <= s3_tag.col;
      row    <= s3_tag.row;
      last   <= s3_tag.last;
    end
  end

  assign line_top = line_rd[2*$bits(pixel_t)-1:$bits(pixel_t)];
  assign line_mid = line_rd[$bits(pixel_t)-1:0];

  mf3_ram #(
    .WIDTH (2 * $bits(pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (ctl.shift),
    .wr_addr (s1_x),
    .wr_data ({line_mid, s1_px}),
    .rd_en   (advance),
    .rd_addr (col_count),
    .rd_data (line_rd)
  );

  mf3_median u_median (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .top_px  (line_top),
    .mid_px  (line_mid),
    .new_px  (s1_px),
    .med_out (med_w)
  );

endmodule

[hw/rtl/mf3_checker.sv]
// Port-level assertions of the 3x3 median filter and their binding to the top level.
module mf3_checker
  import mf3_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pixel_t              median,
  input logic [COL_W-1:0]    col,
  input logic [HEIGHT_W-1:0] row,
  input logic                last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median) && $stable(col)
      && $stable(row) && $stable(last))
    else $error("Output transaction changed while stalled.");

  a_ready_only_blocked_by_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled while no result was waiting.");

  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row != '0)
    else $error("Result reported for a border row.");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .median    (median),
  .col       (col),
  .row       (row),
  .last      (last)
);
